FILE: hw/rtl/mandelbrot_escape_time_macros.svh
// assertion macros for the escape time evaluator
`ifndef MANDELBROT_ESCAPE_TIME_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_MACROS_SVH

// condition holds at every edge out of reset
`define MBET_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define MBET_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define MBET_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/mbet_pkg.sv
// shared constants, types and helper functions of the escape time evaluator
package mbet_pkg;

  localparam int FRAC_BITS = 40;
  localparam int MAX_ITER  = 1000;

  localparam int ROW_W     = 12;
  localparam int COL_W     = 12;
  localparam int DIM_W     = 13;
  localparam int STEP_W    = 48;
  localparam int PAN_W     = 48;
  localparam int CFG_W     = 48;
  localparam int CFG_IDX_W = 3;
  localparam int COUNT_W   = 16;
  localparam int INDEX_W   = 24;

  localparam int STEP_FRAC = 44;
  localparam int PAN_FRAC  = 16;

  localparam int VAL_W = 8 + FRAC_BITS;
  localparam int OFF_W = PAN_W + 1;

  localparam int SH_C  = PAN_FRAC + STEP_FRAC - FRAC_BITS;
  localparam int SH_XY = FRAC_BITS - 1;
  localparam int SH_SQ = FRAC_BITS;

  localparam int MAG_RAW = (VAL_W > OFF_W) ? VAL_W : OFF_W;
  localparam int MAG_W   = MAG_RAW + (MAG_RAW % 2);
  localparam int HALF_W  = MAG_W / 2;
  localparam int ACC_W   = 2 * MAG_W;
  localparam int MUL_STEPS = 4;

  typedef logic signed [VAL_W-1:0] val_t;

  localparam val_t VAL_MAX = val_t'({1'b0, {(VAL_W-1){1'b1}}});
  localparam val_t VAL_MIN = val_t'({1'b1, {(VAL_W-1){1'b0}}});
  localparam logic signed [VAL_W:0] FOUR = (VAL_W+1)'(1) << (FRAC_BITS + 2);

  localparam logic [DIM_W-1:0]  WIDTH_RST  = 13'd600;
  localparam logic [DIM_W-1:0]  HEIGHT_RST = 13'd400;
  localparam logic [STEP_W-1:0] STEP_RST   = 48'd117281240296;
  localparam logic [PAN_W-1:0]  PAN_RST    = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_PIXEL_STEP   = 3'd2,
    REG_PAN_X        = 3'd3,
    REG_PAN_Y        = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    OP_INDEX,
    OP_CRE,
    OP_CIM,
    OP_XY,
    OP_XX,
    OP_YY
  } op_t;

  function automatic logic [MAG_W-1:0] mag(input logic signed [MAG_W-1:0] v);
    return v[MAG_W-1] ? MAG_W'(-v) : MAG_W'(v);
  endfunction

  function automatic val_t sat_add(input val_t a, input val_t b);
    logic signed [VAL_W:0] s;
    s = (VAL_W+1)'(a) + (VAL_W+1)'(b);
    if (s[VAL_W] != s[VAL_W-1]) return s[VAL_W] ? VAL_MIN : VAL_MAX;
    return val_t'(s[VAL_W-1:0]);
  endfunction

  function automatic val_t sat_sub(input val_t a, input val_t b);
    logic signed [VAL_W:0] s;
    s = (VAL_W+1)'(a) - (VAL_W+1)'(b);
    if (s[VAL_W] != s[VAL_W-1]) return s[VAL_W] ? VAL_MIN : VAL_MAX;
    return val_t'(s[VAL_W-1:0]);
  endfunction

endpackage

FILE: hw/rtl/mbet_ifs.sv
// valid/ready channels for pixel requests and escape results
interface mbet_pixel_if
  import mbet_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] pixel_row;
  logic [COL_W-1:0] pixel_col;

  modport source (output valid, output pixel_row, output pixel_col, input ready);
  modport sink   (input valid, input pixel_row, input pixel_col, output ready);
endinterface

interface mbet_result_if
  import mbet_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] iteration_count;
  logic               inside_set;
  logic [INDEX_W-1:0] pixel_index;

  modport source (output valid, output iteration_count, output inside_set,
                  output pixel_index, input ready);
  modport sink   (input valid, input iteration_count, input inside_set,
                  input pixel_index, output ready);
endinterface

FILE: hw/rtl/mandelbrot_escape_time.sv
// escape time evaluator: one pixel at a time through a shared half-width multiplier
// the iteration count of a result is the number of iterations run (1..1000)
// every multiply forms 4 partial products between its load step and its drain and round steps
// each iteration runs three multiplies: x*y, x*x and y*y
// synchronous active-high reset clears the sequencer and output valid, loads config defaults
`include "mandelbrot_escape_time_macros.svh"

module mandelbrot_escape_time
  import mbet_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  mbet_pixel_if.sink           pixel,
  mbet_result_if.source        result
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_LOAD = 7'b0000010,
    S_MUL  = 7'b0000100,
    S_FIN  = 7'b0001000,
    S_UPD  = 7'b0010000,
    S_CHK  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t state, state_next;

  logic [DIM_W-1:0]  image_width;
  logic [DIM_W-1:0]  image_height;
  logic [STEP_W-1:0] pixel_step;
  logic signed [PAN_W-1:0] pan_x;
  logic signed [PAN_W-1:0] pan_y;

  logic [ROW_W-1:0] row_r;
  logic [COL_W-1:0] col_r;
  logic signed [OFF_W-1:0] off_re, off_im;
  val_t c_re, c_im, x, y, x2, y2, dxy, res;
  logic [COUNT_W-1:0] iter;
  op_t op;

  logic [MAG_W-1:0]    ma, mb;
  logic                neg;
  logic [2:0]          cnt;
  logic [MAG_W-1:0]    pp;
  logic [1:0]          pp_pos;
  logic [ACC_W-1:0]    acc;
  logic [INDEX_W-1:0]  index_r;

  logic               out_valid;
  logic [COUNT_W-1:0] out_count;
  logic               out_inside;
  logic [INDEX_W-1:0] out_index;

  logic accept, out_load, escape;
  logic signed [VAL_W:0] sq_sum;
  logic signed [OFF_W-1:0] col_s, row_s, half_w_s, half_h_s, off_re_in, off_im_in;
  logic signed [MAG_W-1:0] opa, opb;
  logic [HALF_W-1:0] a_half, b_half;
  logic [ACC_W-1:0]  pp_term;
  logic [ACC_W-1:0]  q;
  logic              rem, big;
  logic [VAL_W-2:0]  qlo;
  logic [VAL_W-1:0]  mneg;
  val_t              fin_val;

  assign pixel.ready = (state == S_IDLE);
  assign accept      = pixel.valid && pixel.ready;
  assign out_load    = (state == S_DONE) && (!out_valid || result.ready);

  assign result.valid           = out_valid;
  assign result.iteration_count = out_count;
  assign result.inside_set      = out_inside;
  assign result.pixel_index     = out_index;

  // centre-relative offsets in Q32.16 pixels
  assign col_s     = OFF_W'($signed({1'b0, pixel.pixel_col}));
  assign row_s     = OFF_W'($signed({1'b0, pixel.pixel_row}));
  assign half_w_s  = OFF_W'($signed({1'b0, image_width[DIM_W-1:1]}));
  assign half_h_s  = OFF_W'($signed({1'b0, image_height[DIM_W-1:1]}));
  assign off_re_in = ((col_s - half_w_s) <<< PAN_FRAC) + OFF_W'(pan_x);
  assign off_im_in = ((row_s - half_h_s) <<< PAN_FRAC) + OFF_W'(pan_y);

  assign sq_sum = (VAL_W+1)'(x2) + (VAL_W+1)'(y2);
  assign escape = (sq_sum > FOUR) || (iter >= COUNT_W'(MAX_ITER));

  // operand select for the shared multiplier
  always_comb begin
    case (op)
      OP_INDEX: begin
        opa = MAG_W'(row_r);
        opb = MAG_W'(image_width);
      end
      OP_CRE: begin
        opa = MAG_W'(off_re);
        opb = MAG_W'(pixel_step);
      end
      OP_CIM: begin
        opa = MAG_W'(off_im);
        opb = MAG_W'(pixel_step);
      end
      OP_XY: begin
        opa = MAG_W'(x);
        opb = MAG_W'(y);
      end
      OP_XX: begin
        opa = MAG_W'(x);
        opb = MAG_W'(x);
      end
      default: begin
        opa = MAG_W'(y);
        opb = MAG_W'(y);
      end
    endcase
  end

  assign a_half = cnt[0] ? ma[MAG_W-1:HALF_W] : ma[HALF_W-1:0];
  assign b_half = cnt[1] ? mb[MAG_W-1:HALF_W] : mb[HALF_W-1:0];

  always_comb begin
    case (pp_pos)
      2'd0:    pp_term = ACC_W'(pp);
      2'd1:    pp_term = ACC_W'(pp) << HALF_W;
      default: pp_term = ACC_W'(pp) << MAG_W;
    endcase
  end

  // floor shift, sign and saturation of the magnitude product
  always_comb begin
    case (op) inside
      OP_CRE, OP_CIM: begin
        q   = acc >> SH_C;
        rem = |acc[SH_C-1:0];
      end
      OP_XY: begin
        q   = acc >> SH_XY;
        rem = |acc[SH_XY-1:0];
      end
      default: begin
        q   = acc >> SH_SQ;
        rem = |acc[SH_SQ-1:0];
      end
    endcase
    big  = |q[ACC_W-1:VAL_W-1];
    qlo  = q[VAL_W-2:0];
    mneg = {1'b0, qlo} + VAL_W'(rem);
    if (neg) begin
      fin_val = (big || mneg[VAL_W-1]) ? VAL_MIN : -val_t'(mneg);
    end else begin
      fin_val = big ? VAL_MAX : val_t'({1'b0, qlo});
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = S_LOAD;
      S_LOAD: state_next = S_MUL;
      S_MUL:  if (cnt == 3'(MUL_STEPS)) state_next = S_FIN;
      S_FIN:  state_next = (op == OP_INDEX) ? S_LOAD : S_UPD;
      S_UPD: begin
        case (op) inside
          OP_CRE, OP_XY, OP_XX: state_next = S_LOAD;
          default:              state_next = S_CHK;
        endcase
      end
      S_CHK:  state_next = escape ? S_DONE : S_LOAD;
      S_DONE: if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      image_width  <= WIDTH_RST;
      image_height <= HEIGHT_RST;
      pixel_step   <= STEP_RST;
      pan_x        <= PAN_RST;
      pan_y        <= PAN_RST;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_IMAGE_WIDTH:  image_width  <= cfg_data[DIM_W-1:0];
          REG_IMAGE_HEIGHT: image_height <= cfg_data[DIM_W-1:0];
          REG_PIXEL_STEP:   pixel_step   <= cfg_data[STEP_W-1:0];
          REG_PAN_X:        pan_x        <= $signed(cfg_data[PAN_W-1:0]);
          REG_PAN_Y:        pan_y        <= $signed(cfg_data[PAN_W-1:0]);
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          row_r  <= pixel.pixel_row;
          col_r  <= pixel.pixel_col;
          off_re <= off_re_in;
          off_im <= off_im_in;
          x      <= '0;
          y      <= '0;
          x2     <= '0;
          y2     <= '0;
          iter   <= '0;
          op     <= OP_INDEX;
        end
      end
      S_LOAD: begin
        ma  <= mag(opa);
        mb  <= mag(opb);
        neg <= opa[MAG_W-1] ^ opb[MAG_W-1];
        acc <= '0;
        cnt <= '0;
      end
      S_MUL: begin
        if (cnt < 3'(MUL_STEPS)) begin
          pp     <= MAG_W'(a_half * b_half);
          pp_pos <= {1'b0, cnt[0]} + {1'b0, cnt[1]};
        end
        if (cnt != 3'd0) begin
          acc <= acc + pp_term;
        end
        cnt <= cnt + 3'd1;
      end
      S_FIN: begin
        if (op == OP_INDEX) begin
          index_r <= acc[INDEX_W-1:0] + INDEX_W'(col_r);
          op      <= OP_CRE;
        end else begin
          res <= fin_val;
        end
      end
      S_UPD: begin
        case (op)
          OP_CRE: begin
            c_re <= res;
            op   <= OP_CIM;
          end
          OP_CIM: c_im <= res;
          OP_XY: begin
            y  <= sat_add(res, c_im);
            x  <= sat_add(dxy, c_re);
            op <= OP_XX;
          end
          OP_XX: begin
            x2 <= res;
            op <= OP_YY;
          end
          OP_YY: begin
            y2   <= res;
            iter <= iter + COUNT_W'(1);
          end
          default: ;
        endcase
      end
      S_CHK: begin
        if (!escape) begin
          dxy <= sat_sub(x2, y2);
          op  <= OP_XY;
        end
      end
      S_DONE: begin
        if (out_load) begin
          out_count  <= iter;
          out_inside <= (iter >= COUNT_W'(MAX_ITER));
          out_index  <= index_r;
        end
      end
      default: ;
    endcase
  end

  `MBET_ASSERT_IMP(a_iter_bound, clk, rst, state != S_IDLE, iter <= COUNT_W'(MAX_ITER), "iteration count past limit")
  `MBET_ASSERT_IMP(a_inside_count, clk, rst, result.valid, result.inside_set == (result.iteration_count == COUNT_W'(MAX_ITER)), "inside flag disagrees with count")
  `MBET_ASSERT_NEXT(a_accept_load, clk, rst, accept, state == S_LOAD && op == OP_INDEX, "accepted transaction did not start index multiply")
  `MBET_ASSERT_IMP(a_sq_nonneg, clk, rst, state == S_CHK, !x2[VAL_W-1] && !y2[VAL_W-1], "square went negative")

endmodule
